/* src/sfe_pkg.sv */
`timescale 1ns / 1ps

package sfe_pkg;

  // frame geometry
  localparam int CHANNEL_COUNT_DEF = 16;
  localparam int VAL_W             = 12;
  localparam int CODE_W            = 11;
  localparam int BYTE_W            = 8;

  // magnitude of the mapping numerator stays below 2**24
  localparam int NUM_MAG_W = 24;
  localparam int MUL_STEPS = CODE_W;
  localparam int DIV_STEPS = NUM_MAG_W;

  localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h0F;
  localparam logic [BYTE_W-1:0] FRAME_FOOTER = 8'h00;
  localparam int FLAG_LOSS_BIT = 2;
  localparam int FLAG_FS_BIT   = 3;

  // register map, word index
  localparam logic [1:0] REG_IN_MIN  = 2'd0;
  localparam logic [1:0] REG_IN_MAX  = 2'd1;
  localparam logic [1:0] REG_OUT_MIN = 2'd2;
  localparam logic [1:0] REG_OUT_MAX = 2'd3;

  localparam logic [VAL_W-1:0]  IN_MIN_RST  = 12'd1000;
  localparam logic [VAL_W-1:0]  IN_MAX_RST  = 12'd2000;
  localparam logic [CODE_W-1:0] OUT_MIN_RST = 11'd173;
  localparam logic [CODE_W-1:0] OUT_MAX_RST = 11'd1811;

  typedef struct packed {
    logic [VAL_W-1:0]  in_min;
    logic [VAL_W-1:0]  in_max;
    logic [CODE_W-1:0] out_min;
    logic [CODE_W-1:0] out_max;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } map_res_t;

endpackage

/* src/sfe_cfg.sv */
`timescale 1ns / 1ps

module sfe_cfg import sfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IN_MIN:  cfg_nxt.in_min  = cfg_pwdata[VAL_W-1:0];
        REG_IN_MAX:  cfg_nxt.in_max  = cfg_pwdata[VAL_W-1:0];
        REG_OUT_MIN: cfg_nxt.out_min = cfg_pwdata[CODE_W-1:0];
        REG_OUT_MAX: cfg_nxt.out_max = cfg_pwdata[CODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_MIN:  cfg_prdata = 32'(cfg_r.in_min);
      REG_IN_MAX:  cfg_prdata = 32'(cfg_r.in_max);
      REG_OUT_MIN: cfg_prdata = 32'(cfg_r.out_min);
      REG_OUT_MAX: cfg_prdata = 32'(cfg_r.out_max);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_min  <= IN_MIN_RST;
      cfg_r.in_max  <= IN_MAX_RST;
      cfg_r.out_min <= OUT_MIN_RST;
      cfg_r.out_max <= OUT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/sfe_map.sv */
`timescale 1ns / 1ps

module sfe_map import sfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] in_value,
  input  cfg_t             cfg,
  output map_res_t         res
);

  localparam int ACC_W = NUM_MAG_W + 1;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_PREP = 3'd2;
  localparam logic [2:0] M_DIV  = 3'd3;
  localparam logic [2:0] M_FIN  = 3'd4;

  logic [2:0]           st_r, st_nxt;
  logic [4:0]           step_r, step_nxt;
  logic                 vld_r, vld_nxt;

  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     a1s_r, a1s_nxt;
  logic [ACC_W-1:0]     a2s_r, a2s_nxt;
  logic [CODE_W-1:0]    m1_r, m1_nxt;
  logic [CODE_W-1:0]    m2_r, m2_nxt;
  logic [VAL_W:0]       den_r, den_nxt;
  logic [NUM_MAG_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]     dmag_r, dmag_nxt;
  logic [VAL_W-1:0]     rem_r, rem_nxt;
  logic [CODE_W-1:0]    quo_r, quo_nxt;
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic                 neg_r, neg_nxt;

  // operand set-up
  logic [VAL_W:0]       diff_w;
  logic [CODE_W:0]      span_w;
  logic [VAL_W:0]       den_w;
  logic [VAL_W:0]       a1_w;
  logic [CODE_W:0]      span_neg_w;
  logic [VAL_W:0]       den_neg_w;

  // per-step datapath
  logic [ACC_W-1:0]     add1_w, add2_w;
  logic [ACC_W-1:0]     acc_abs_w;
  logic [VAL_W:0]       trial_w, sub_w;
  logic                 ge_w;

  assign diff_w     = {1'b0, in_value} - {1'b0, cfg.in_min};
  assign span_w     = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
  assign den_w      = {1'b0, cfg.in_max} - {1'b0, cfg.in_min};
  assign span_neg_w = -span_w;
  // sign of the span moves onto the other factor so the multiplier bits are unsigned
  assign a1_w       = span_w[CODE_W] ? -diff_w : diff_w;

  assign add1_w     = m1_r[0] ? a1s_r : '0;
  assign add2_w     = m2_r[0] ? a2s_r : '0;
  assign acc_abs_w  = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign den_neg_w  = -den_r;

  assign trial_w    = {rem_r, dvd_r[NUM_MAG_W-1]};
  assign ge_w       = trial_w >= {1'b0, dmag_r};
  assign sub_w      = trial_w - {1'b0, dmag_r};

  assign res.valid  = vld_r;
  assign res.code   = code_r;

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    vld_nxt  = vld_r;
    acc_nxt  = acc_r;
    a1s_nxt  = a1s_r;
    a2s_nxt  = a2s_r;
    m1_nxt   = m1_r;
    m2_nxt   = m2_r;
    den_nxt  = den_r;
    dvd_nxt  = dvd_r;
    dmag_nxt = dmag_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    code_nxt = code_r;
    neg_nxt  = neg_r;
    unique case (st_r)
      M_IDLE: begin
        if (start) begin
          vld_nxt  = 1'b0;
          den_nxt  = den_w;
          acc_nxt  = '0;
          a1s_nxt  = {{(ACC_W-VAL_W-1){a1_w[VAL_W]}}, a1_w};
          a2s_nxt  = {{(ACC_W-VAL_W-1){den_w[VAL_W]}}, den_w};
          m1_nxt   = span_w[CODE_W] ? span_neg_w[CODE_W-1:0] : span_w[CODE_W-1:0];
          m2_nxt   = cfg.out_min;
          step_nxt = '0;
          if (den_w == '0) begin
            // equal input bounds map everything to out_min
            code_nxt = cfg.out_min;
            vld_nxt  = 1'b1;
          end else begin
            st_nxt = M_MUL;
          end
        end
      end
      M_MUL: begin
        // one multiplier bit of each product per cycle
        acc_nxt  = acc_r + add1_w + add2_w;
        a1s_nxt  = {a1s_r[ACC_W-2:0], 1'b0};
        a2s_nxt  = {a2s_r[ACC_W-2:0], 1'b0};
        m1_nxt   = {1'b0, m1_r[CODE_W-1:1]};
        m2_nxt   = {1'b0, m2_r[CODE_W-1:1]};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(MUL_STEPS - 1)) begin
          st_nxt = M_PREP;
        end
      end
      M_PREP: begin
        neg_nxt  = acc_r[ACC_W-1] ^ den_r[VAL_W];
        dvd_nxt  = acc_abs_w[NUM_MAG_W-1:0];
        dmag_nxt = den_r[VAL_W] ? den_neg_w[VAL_W-1:0] : den_r[VAL_W-1:0];
        rem_nxt  = '0;
        quo_nxt  = '0;
        step_nxt = '0;
        st_nxt   = M_DIV;
      end
      M_DIV: begin
        // restoring division, one quotient bit per cycle; only the low code bits are kept
        rem_nxt  = ge_w ? sub_w[VAL_W-1:0] : trial_w[VAL_W-1:0];
        quo_nxt  = {quo_r[CODE_W-2:0], ge_w};
        dvd_nxt  = {dvd_r[NUM_MAG_W-2:0], 1'b0};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(DIV_STEPS - 1)) begin
          st_nxt = M_FIN;
        end
      end
      M_FIN: begin
        code_nxt = neg_r ? -quo_r : quo_r;
        vld_nxt  = 1'b1;
        st_nxt   = M_IDLE;
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      step_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    a1s_r  <= a1s_nxt;
    a2s_r  <= a2s_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    den_r  <= den_nxt;
    dvd_r  <= dvd_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    code_r <= code_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

/* src/sfe_pack.sv */
`timescale 1ns / 1ps

module sfe_pack import sfe_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  output logic              map_start,
  input  map_res_t          map_res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  localparam int IDX_W = $clog2(CHANNEL_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_COUNT - 1);
  localparam logic [3:0] BITS_PER_CODE = 4'(CODE_W);
  localparam logic [3:0] BITS_PER_BYTE = 4'(BYTE_W);
  localparam logic [2:0] FILL_FULL     = 3'(BYTE_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_BITS = 3'd3;
  localparam logic [2:0] ST_FLAG = 3'd4;
  localparam logic [2:0] ST_FOOT = 3'd5;

  logic [2:0]        st_r, st_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [3:0]        bcnt_r, bcnt_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        flags_r, flags_nxt;
  logic [CODE_W-1:0] sh_r, sh_nxt;
  logic [BYTE_W-1:0] asm_r, asm_nxt;
  logic [BYTE_W-1:0] od_r, od_nxt;
  logic              ol_r, ol_nxt;
  logic              oe_r, oe_nxt;

  logic              slot_free;
  logic              last_ch;

  assign in_tready  = (st_r == ST_IDLE);
  assign map_start  = in_tvalid & in_tready;
  assign slot_free  = ~ov_r | out_tready;
  assign last_ch    = (idx_r == LAST_IDX);

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = oe_r;

  always_comb begin
    logic [BYTE_W-1:0] flag_byte;
    flag_byte = '0;
    flag_byte[FLAG_LOSS_BIT] = flags_r[0];
    flag_byte[FLAG_FS_BIT]   = flags_r[1];

    st_nxt    = st_r;
    idx_nxt   = idx_r;
    bcnt_nxt  = bcnt_r;
    fill_nxt  = fill_r;
    flags_nxt = flags_r;
    sh_nxt    = sh_r;
    asm_nxt   = asm_r;
    ov_nxt    = ov_r & ~out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          flags_nxt = in_tuser;
          st_nxt    = (idx_r == '0) ? ST_HDR : ST_WAIT;
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = FRAME_HEADER;
          ol_nxt = 1'b0;
          oe_nxt = 1'b0;
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (map_res.valid) begin
          sh_nxt   = map_res.code;
          bcnt_nxt = BITS_PER_CODE;
          st_nxt   = ST_BITS;
        end
      end
      ST_BITS: begin
        // one code bit per cycle into the byte assembler, lsb first, unless a full byte waits for a free output slot
        if ((fill_r != FILL_FULL) || slot_free) begin
          asm_nxt  = {sh_r[0], asm_r[BYTE_W-1:1]};
          sh_nxt   = {1'b0, sh_r[CODE_W-1:1]};
          fill_nxt = fill_r + 3'd1;
          bcnt_nxt = bcnt_r - 4'd1;
          if (fill_r == FILL_FULL) begin
            ov_nxt = 1'b1;
            od_nxt = {sh_r[0], asm_r[BYTE_W-1:1]};
            // no further byte completes from this code; on the last channel the footer carries tlast
            ol_nxt = (bcnt_r <= BITS_PER_BYTE) & ~last_ch;
            oe_nxt = 1'b0;
          end
          if (bcnt_r == 4'd1) begin
            if (last_ch) begin
              st_nxt = ST_FLAG;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
              st_nxt  = ST_IDLE;
            end
          end
        end
      end
      ST_FLAG: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = flag_byte;
          ol_nxt = 1'b0;
          oe_nxt = 1'b0;
          st_nxt = ST_FOOT;
        end
      end
      ST_FOOT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          od_nxt   = FRAME_FOOTER;
          ol_nxt   = 1'b1;
          oe_nxt   = 1'b1;
          idx_nxt  = '0;
          fill_nxt = '0;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      idx_r  <= '0;
      bcnt_r <= '0;
      fill_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      bcnt_r <= bcnt_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    sh_r    <= sh_nxt;
    asm_r   <= asm_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
    oe_r    <= oe_nxt;
  end

endmodule

/* src/sbus_frame_encoder.sv */
`timescale 1ns / 1ps

// channel  direction  handshake                   payload
// in_      slave      in_tvalid / in_tready        in_tdata: channel value; in_tuser: flags
// out_     master     out_tvalid / out_tready      out_tdata: frame byte; tlast, tuser
// cfg_     apb slave  psel, penable, pwrite        in_min, in_max, out_min, out_max
//
// an item passes through start, 11 multiplier and 24 divider steps, set-up, finish,
// the load of the code into the packer and one packer step per code bit, with the
// header before the first channel and the flag byte and footer after the last; equal
// input bounds skip the arithmetic; synchronous reset
// in_tready is high only while the sequencer is idle; a stalled out_ side holds the
// bit packer at the next complete byte, and an item may be taken while a byte waits

module sbus_frame_encoder import sfe_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] channel_value, [15:12] zero
  input  logic [1:0]  in_tuser,     // [0] signal_loss, [1] failsafe

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] frame_byte
  output logic        out_tlast,    // last byte caused by the current item
  output logic        out_tuser,    // [0] frame_end, footer byte

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg;
  map_res_t map_res;
  logic     map_start;

  // register file: in_min at 0x0, in_max at 0x4, out_min at 0x8, out_max at 0xc
  sfe_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // linear map to an 11-bit code: shift-add products, then a restoring divide
  // truncated toward zero, low 11 bits kept
  sfe_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (map_start),
    .in_value (in_tdata[VAL_W-1:0]),
    .cfg      (cfg),
    .res      (map_res)
  );

  // frame sequencer: header before the first channel, code bits packed lsb first
  // into bytes, flag byte and footer after the last channel
  sfe_pack #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .map_start  (map_start),
    .map_res    (map_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* tb/sbus_frame_encoder_tb.sv */
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] data;
  logic       last;
  logic       frame_end;
} frame_byte_t;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

class frame_scoreboard;
  logic [sfe_pkg::VAL_W-1:0]  in_min, in_max;
  logic [sfe_pkg::CODE_W-1:0] out_min, out_max;
  logic [3:0]                 chan_idx;
  logic [6:0]                 carry_bits;
  logic [2:0]                 carry_cnt;
  frame_byte_t                expected[$];
  int                         errors, items, bytes_seen, frames, settings;

  function new();
    in_min     = sfe_pkg::IN_MIN_RST;
    in_max     = sfe_pkg::IN_MAX_RST;
    out_min    = sfe_pkg::OUT_MIN_RST;
    out_max    = sfe_pkg::OUT_MAX_RST;
    chan_idx   = '0;
    carry_bits = '0;
    carry_cnt  = '0;
    errors     = 0;
    items      = 0;
    bytes_seen = 0;
    frames     = 0;
    settings   = 1;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      sfe_pkg::REG_IN_MIN:  in_min  = val[sfe_pkg::VAL_W-1:0];
      sfe_pkg::REG_IN_MAX:  in_max  = val[sfe_pkg::VAL_W-1:0];
      sfe_pkg::REG_OUT_MIN: out_min = val[sfe_pkg::CODE_W-1:0];
      sfe_pkg::REG_OUT_MAX: out_max = val[sfe_pkg::CODE_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [1:0] idx);
    logic [31:0] val;
    case (idx)
      sfe_pkg::REG_IN_MIN:  val = {20'd0, in_min};
      sfe_pkg::REG_IN_MAX:  val = {20'd0, in_max};
      sfe_pkg::REG_OUT_MIN: val = {21'd0, out_min};
      default:              val = {21'd0, out_max};
    endcase
    return val;
  endfunction

  // linear map, exact quotient truncated toward zero, low 11 bits kept
  function logic [sfe_pkg::CODE_W-1:0] map_code(logic [sfe_pkg::VAL_W-1:0] v);
    longint lo_in, hi_in, lo_out, hi_out, val, den, num, quo;
    lo_in  = in_min;
    hi_in  = in_max;
    lo_out = out_min;
    hi_out = out_max;
    val    = v;
    den    = hi_in - lo_in;
    if (den == 0) return out_min;
    num = (val - lo_in) * (hi_out - lo_out) + lo_out * den;
    quo = num / den;
    return quo[sfe_pkg::CODE_W-1:0];
  endfunction

  function void push_byte(logic [7:0] data, logic frame_end);
    frame_byte_t fb;
    fb.data      = data;
    fb.last      = 1'b0;
    fb.frame_end = frame_end;
    expected.push_back(fb);
  endfunction

  function void note_item(logic [sfe_pkg::VAL_W-1:0] v, logic loss, logic fs);
    logic [17:0] acc;
    logic [4:0]  cnt;
    logic [7:0]  flags;
    items++;
    if (chan_idx == 0) push_byte(sfe_pkg::FRAME_HEADER, 1'b0);
    acc = {11'd0, carry_bits} | ({7'd0, map_code(v)} << carry_cnt);
    cnt = 5'(carry_cnt) + 5'd11;
    while (cnt >= 5'd8) begin
      push_byte(acc[7:0], 1'b0);
      acc = acc >> 8;
      cnt = cnt - 5'd8;
    end
    carry_bits = acc[6:0];
    carry_cnt  = cnt[2:0];
    if (chan_idx == 4'(sfe_pkg::CHANNEL_COUNT_DEF - 1)) begin
      flags = '0;
      flags[sfe_pkg::FLAG_LOSS_BIT] = loss;
      flags[sfe_pkg::FLAG_FS_BIT]   = fs;
      push_byte(flags, 1'b0);
      push_byte(sfe_pkg::FRAME_FOOTER, 1'b1);
      chan_idx   = '0;
      carry_bits = '0;
      carry_cnt  = '0;
      frames++;
    end else begin
      chan_idx = chan_idx + 4'd1;
    end
    expected[expected.size()-1].last = 1'b1;
  endfunction

  function void check_byte(logic [7:0] data, logic last, logic frame_end);
    frame_byte_t fb;
    bytes_seen++;
    if (expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected frame byte, expected none, got data %02h last %0b end %0b",
               $time, data, last, frame_end);
      return;
    end
    fb = expected.pop_front();
    if (data !== fb.data || last !== fb.last || frame_end !== fb.frame_end) begin
      errors++;
      $display("%0t: byte mismatch, expected %02h/%0b/%0b, got %02h/%0b/%0b",
               $time, fb.data, fb.last, fb.frame_end, data, last, frame_end);
    end
  endfunction
endclass

module sbus_frame_encoder_tb;
  import sfe_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [11:0] channel_value, [15:12] zero
  logic [1:0]  in_tuser;   // [0] signal_loss, [1] failsafe
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] frame_byte
  logic        out_tlast;
  logic        out_tuser;  // [0] frame_end
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_scoreboard sb;
  idle_mode_t      idle_mode;

  sbus_frame_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // hard limit, several times the slowest legal run
  initial begin
    #2000000;
    $display("sbus_frame_encoder verification failed");
    $finish;
  end

  // chance in a hundred that a given side idles in a given cycle
  function automatic int idle_pct(bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender ? 79 : 0;
      IDLE_RECEIVER: return sender ? 0 : 79;
      IDLE_BOTH:     return 14;
      default:       return 0;
    endcase
  endfunction

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= idle_pct(1'b0));
  end

  // every byte taken at a rising edge goes straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  // one item on the input channel; entered and left on a falling edge
  task automatic send_channel(input logic [VAL_W-1:0] value, input logic loss,
                              input logic fs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct(1'b1)) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {4'd0, value};
    in_tuser  = {fs, loss};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(value, loss, fs);
    @(negedge clk);
  endtask

  // two-phase register access, setup then access
  task automatic cfg_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // sender holds off until every expected byte is out, then lets the sequencer settle
  task automatic drain_frames();
    in_tvalid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  // write all four bounds while idle, reading each one back
  task automatic load_bounds(input logic [11:0] lo_in, input logic [11:0] hi_in,
                             input logic [10:0] lo_out, input logic [10:0] hi_out);
    logic [31:0] vals[4];
    logic [31:0] rd;
    logic [1:0]  idx;
    vals[REG_IN_MIN]  = {20'd0, lo_in};
    vals[REG_IN_MAX]  = {20'd0, hi_in};
    vals[REG_OUT_MIN] = {21'd0, lo_out};
    vals[REG_OUT_MAX] = {21'd0, hi_out};
    drain_frames();
    for (int i = 0; i < 4; i++) begin
      idx = 2'(i);
      cfg_access(1'b1, idx, vals[i], rd);
      sb.set_reg(idx, vals[i]);
    end
    for (int i = 0; i < 4; i++) begin
      idx = 2'(i);
      cfg_access(1'b0, idx, 32'd0, rd);
      if (rd !== sb.reg_value(idx)) begin
        sb.errors++;
        $display("%0t: register %0d readback, expected %08h, got %08h",
                 $time, idx, sb.reg_value(idx), rd);
      end
    end
    sb.settings++;
  endtask

  // random channel items: mostly anywhere, some at the field extremes, some
  // within two of the configured input bounds, some between 1200 and 2000
  task automatic send_random(input int count);
    logic [VAL_W-1:0] value;
    int               pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 6)       value = VAL_W'($urandom_range(4095));
      else if (pick == 6) value = $urandom_range(1) ? 12'd0 : 12'd4095;
      else if (pick == 7) value = sb.in_min + VAL_W'($urandom_range(2));
      else if (pick == 8) value = sb.in_max - VAL_W'($urandom_range(2));
      else                value = VAL_W'($urandom_range(1200, 2000));
      send_channel(value, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // a random phase: new bounds, new idling pattern, a batch of items
  task automatic run_phase(input idle_mode_t mode, input logic [11:0] lo_in,
                           input logic [11:0] hi_in, input logic [10:0] lo_out,
                           input logic [10:0] hi_out);
    load_bounds(lo_in, hi_in, lo_out, hi_out);
    idle_mode = mode;
    send_random(32);
  endtask

  logic [VAL_W-1:0] first_frame[16] = '{
    12'd0, 12'd4095, 12'd1000, 12'd2000, 12'd1500, 12'd999, 12'd2001, 12'd1,
    12'd4094, 12'd2048, 12'd1234, 12'd3000, 12'd500, 12'd1750, 12'd1999, 12'd1000
  };

  initial begin
    sb          = new();
    idle_mode   = IDLE_NONE;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // one whole frame on the reset bounds: values far below and above the
    // input range (negative and oversized codes wrap to 11 bits), both
    // flags raised on channels where they must be ignored, and both flags
    // set on the last channel
    for (int i = 0; i < 16; i++) begin
      send_channel(first_frame[i], 1'(i % 2), 1'((i / 2) % 2));
    end

    // equal input bounds always give out_min, whatever the channel value
    load_bounds(12'd2048, 12'd2048, 11'd2047, 11'd0);
    send_channel(12'd0, 1'b1, 1'b0);
    send_channel(12'd2048, 1'b0, 1'b1);
    send_channel(12'd4095, 1'b1, 1'b1);

    // reversed input bounds, no clamping
    load_bounds(12'd4095, 12'd0, 11'd0, 11'd2047);
    send_channel(12'd0, 1'b0, 1'b0);
    send_channel(12'd4095, 1'b1, 1'b0);
    send_channel(12'd2047, 1'b0, 1'b1);

    // random part, one setting per phase, idling pattern cycled through
    run_phase(IDLE_NONE, 12'd0, 12'd4095, 11'd0, 11'd2047);
    run_phase(IDLE_SENDER, 12'd4095, 12'd0, 11'd2047, 11'd0);
    run_phase(IDLE_RECEIVER, 12'($urandom_range(800, 1200)), 12'($urandom_range(1800, 2200)),
              11'($urandom_range(150, 250)), 11'($urandom_range(1700, 1900)));
    run_phase(IDLE_BOTH, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
              11'($urandom_range(2047)), 11'($urandom_range(2047)));
    begin
      logic [11:0] same_bound;
      same_bound = 12'($urandom_range(4095));
      run_phase(IDLE_SENDER, same_bound, same_bound, 11'($urandom_range(2047)),
                11'($urandom_range(2047)));
    end
    run_phase(IDLE_RECEIVER, IN_MIN_RST, IN_MAX_RST, OUT_MIN_RST, OUT_MAX_RST);
    run_phase(IDLE_BOTH, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
              11'($urandom_range(2047)), 11'($urandom_range(2047)));
    run_phase(IDLE_NONE, 12'($urandom_range(800, 1200)), 12'($urandom_range(1800, 2200)),
              11'($urandom_range(150, 250)), 11'($urandom_range(1700, 1900)));

    // let the last bytes out, then give the block time to show strays
    drain_frames();

    $display("run covered %0d channel items and %0d frame bytes, %0d full frames,",
             sb.items, sb.bytes_seen, sb.frames);
    $display("over %0d bound settings with every idling pattern; %0d mismatches",
             sb.settings, sb.errors);
    if (sb.errors == 0) begin
      $display("sbus_frame_encoder verification clean");
    end else begin
      $display("sbus_frame_encoder verification failed");
    end
    $finish;
  end
endmodule
